// File: rtl/lcg_pkg.sv
// ----------------------------------------------------------------------------
// lcg_pkg
// Shared types and constants for the linear congruential generator: word
// width, reset values, register and command codes, state types.
// ----------------------------------------------------------------------------
package lcg_pkg;

    localparam int LCG_W     = 32;
    localparam int LCG_CNT_W = $clog2(LCG_W);
    localparam int APB_AW    = 4;

    localparam logic [LCG_W-1:0] LCG_RESET_MULT = LCG_W'(65539);
    localparam logic [LCG_W-1:0] LCG_RESET_SEED = LCG_W'(1);

    // Configuration register index (paddr[3:2])
    typedef enum logic [1:0] {
        REG_MULT = 2'd0,
        REG_INCR = 2'd1,
        REG_MOD  = 2'd2
    } reg_idx_t;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_STEP      = 2'd0,
        CMD_LOAD      = 2'd1,
        CMD_LOAD_STEP = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } top_state_t;

    typedef enum logic [1:0] {
        AR_IDLE,
        AR_MUL,
        AR_MOD
    } arith_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_status_t;

endpackage

// File: rtl/lcg_if.sv
// ----------------------------------------------------------------------------
// lcg_if
// Valid/ready channel interfaces for the command and result beats.
// ----------------------------------------------------------------------------
interface lcg_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] seed_value;

    modport source (output valid, output cmd, output seed_value, input ready);
    modport sink   (input valid, input cmd, input seed_value, output ready);
endinterface

interface lcg_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

// File: rtl/lcg_arith.sv
// ----------------------------------------------------------------------------
// lcg_arith
// Serial arithmetic unit: shift-add multiply (one multiplier bit a cycle)
// seeded with the increment, then an optional restoring remainder (one
// dividend bit a cycle) against the modulus.
// ----------------------------------------------------------------------------
module lcg_arith (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lcg_pkg::LCG_W-1:0]    seed,
    input  logic [lcg_pkg::LCG_W-1:0]    mult,
    input  logic [lcg_pkg::LCG_W-1:0]    incr,
    input  logic [lcg_pkg::LCG_W-1:0]    modulus,
    output lcg_pkg::arith_status_t       status,
    output logic [lcg_pkg::LCG_W-1:0]    result
);

    lcg_pkg::arith_state_t               st_reg, st_next;
    logic [lcg_pkg::LCG_CNT_W-1:0]       cnt_reg, cnt_next;
    logic                                done_reg, done_next;
    logic [lcg_pkg::LCG_W-1:0]           acc_reg, acc_next;
    logic [lcg_pkg::LCG_W-1:0]           md_reg, md_next;
    logic [lcg_pkg::LCG_W-1:0]           mul_sh_reg, mul_sh_next;
    logic [lcg_pkg::LCG_W-1:0]           modv_reg, modv_next;
    logic [lcg_pkg::LCG_W-1:0]           rem_reg, rem_next;
    logic [lcg_pkg::LCG_W-1:0]           div_sh_reg, div_sh_next;
    logic [lcg_pkg::LCG_W-1:0]           result_reg, result_next;

    logic [lcg_pkg::LCG_W-1:0]           acc_sum;
    logic [lcg_pkg::LCG_W:0]             rem_sh;
    logic [lcg_pkg::LCG_W:0]             rem_new;
    logic                                last;

    // Datapath: one partial product or one remainder step
    always_comb
    begin
        acc_sum = acc_reg + (mul_sh_reg[0] ? md_reg : '0);
        rem_sh  = {rem_reg, div_sh_reg[lcg_pkg::LCG_W-1]};
        if (rem_sh >= {1'b0, modv_reg})
        begin
            rem_new = rem_sh - {1'b0, modv_reg};
        end
        else
        begin
            rem_new = rem_sh;
        end
        last = (cnt_reg == lcg_pkg::LCG_CNT_W'(lcg_pkg::LCG_W - 1));
    end

    // Sequencer: next state and datapath loads
    always_comb
    begin
        st_next     = st_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        acc_next    = acc_reg;
        md_next     = md_reg;
        mul_sh_next = mul_sh_reg;
        modv_next   = modv_reg;
        rem_next    = rem_reg;
        div_sh_next = div_sh_reg;
        result_next = result_reg;
        unique case (st_reg)
            lcg_pkg::AR_IDLE:
            begin
                if (start)
                begin
                    acc_next    = incr;
                    md_next     = seed;
                    mul_sh_next = mult;
                    modv_next   = modulus;
                    cnt_next    = '0;
                    st_next     = lcg_pkg::AR_MUL;
                end
            end
            lcg_pkg::AR_MUL:
            begin
                acc_next    = acc_sum;
                md_next     = md_reg << 1;
                mul_sh_next = mul_sh_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (last)
                begin
                    cnt_next = '0;
                    if (modv_reg != '0)
                    begin
                        div_sh_next = acc_sum;
                        rem_next    = '0;
                        st_next     = lcg_pkg::AR_MOD;
                    end
                    else
                    begin
                        result_next = acc_sum;
                        done_next   = 1'b1;
                        st_next     = lcg_pkg::AR_IDLE;
                    end
                end
            end
            lcg_pkg::AR_MOD:
            begin
                rem_next    = rem_new[lcg_pkg::LCG_W-1:0];
                div_sh_next = div_sh_reg << 1;
                cnt_next    = cnt_reg + 1'b1;
                if (last)
                begin
                    cnt_next    = '0;
                    result_next = rem_new[lcg_pkg::LCG_W-1:0];
                    done_next   = 1'b1;
                    st_next     = lcg_pkg::AR_IDLE;
                end
            end
            default:
            begin
                st_next = lcg_pkg::AR_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= lcg_pkg::AR_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        md_reg     <= md_next;
        mul_sh_reg <= mul_sh_next;
        modv_reg   <= modv_next;
        rem_reg    <= rem_next;
        div_sh_reg <= div_sh_next;
        result_reg <= result_next;
    end

    assign status.busy = (st_reg != lcg_pkg::AR_IDLE);
    assign status.done = done_reg;
    assign result      = result_reg;

endmodule

// File: rtl/lcg_random_generator.sv
// ----------------------------------------------------------------------------
// lcg_random_generator
// Linear congruential generator: seed = (seed * mult + incr) mod modulus,
// with a zero modulus meaning a plain 32-bit wrap.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries command beats (cmd, seed_value). Step emits the next value,
//   load replaces the seed and emits nothing, load-and-step does both; cmd 3
//   is dropped. out_ch carries one random_value beat per step.
//   The APB port writes multiplier (0x0), increment (0x4), modulus (0x8);
//   write only while no command is in flight.
// Sequencing:
//   A load only replaces the seed. A step runs a bit-serial multiply and,
//   when modulus is non-zero, a restoring remainder after it; the value is
//   then registered as the output beat, and only after that is the next
//   command taken, so one command is in work at a time.
// Reset:
//   multiplier 65539, increment 0, modulus 0, seed 1, no result pending.
// Back-pressure:
//   A finished value sits in the output register while the next command is
//   taken; a second result waits in the seed until the register is free,
//   and no further command is taken meanwhile.
// ----------------------------------------------------------------------------
module lcg_random_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    lcg_in_if.sink                         in_ch,
    lcg_out_if.source                      out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lcg_pkg::APB_AW-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    lcg_pkg::top_state_t               state_reg, state_next;
    logic [lcg_pkg::LCG_W-1:0]         seed_reg, seed_next;
    logic                              start_reg, start_next;
    logic                              out_valid_reg, out_valid_next;
    logic [lcg_pkg::LCG_W-1:0]         out_data_reg, out_data_next;
    logic [lcg_pkg::LCG_W-1:0]         mult_reg, incr_reg, mod_reg;

    lcg_pkg::arith_status_t            arith_st;
    logic [lcg_pkg::LCG_W-1:0]         arith_result;
    logic                              in_fire;
    logic                              out_free;
    logic                              cfg_wr;
    lcg_pkg::reg_idx_t                 cfg_idx;

    assign cfg_idx = lcg_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= lcg_pkg::LCG_RESET_MULT;
            incr_reg <= '0;
            mod_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                lcg_pkg::REG_MULT: mult_reg <= pwdata;
                lcg_pkg::REG_INCR: incr_reg <= pwdata;
                lcg_pkg::REG_MOD:  mod_reg  <= pwdata;
                default:           ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (cfg_idx)
            lcg_pkg::REG_MULT: prdata = mult_reg;
            lcg_pkg::REG_INCR: prdata = incr_reg;
            lcg_pkg::REG_MOD:  prdata = mod_reg;
            default:           prdata = '0;
        endcase
    end

    lcg_arith u_arith (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .seed    (seed_reg),
        .mult    (mult_reg),
        .incr    (incr_reg),
        .modulus (mod_reg),
        .status  (arith_st),
        .result  (arith_result)
    );

    assign in_ch.ready = (state_reg == lcg_pkg::ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    // Command sequencing and result hand-over
    always_comb
    begin
        state_next     = state_reg;
        seed_next      = seed_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            lcg_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (lcg_pkg::cmd_t'(in_ch.cmd))
                        lcg_pkg::CMD_STEP:
                        begin
                            start_next = 1'b1;
                            state_next = lcg_pkg::ST_RUN;
                        end
                        lcg_pkg::CMD_LOAD:
                        begin
                            seed_next = in_ch.seed_value;
                        end
                        lcg_pkg::CMD_LOAD_STEP:
                        begin
                            seed_next  = in_ch.seed_value;
                            start_next = 1'b1;
                            state_next = lcg_pkg::ST_RUN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            lcg_pkg::ST_RUN:
            begin
                if (arith_st.done)
                begin
                    seed_next = arith_result;
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = arith_result;
                        state_next     = lcg_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = lcg_pkg::ST_HOLD;
                    end
                end
            end
            lcg_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = seed_reg;
                    state_next     = lcg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcg_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state, seed and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcg_pkg::ST_IDLE;
            seed_reg      <= lcg_pkg::LCG_RESET_SEED;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.random_value = out_data_reg;

`ifndef SYNTHESIS
    // A new command is only taken when the serial unit is free
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !arith_st.busy)
        else $error("command taken while arithmetic busy");

    // The unit only finishes while a step is outstanding
    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        arith_st.done |-> (state_reg == lcg_pkg::ST_RUN))
        else $error("arithmetic done outside a step");

    // A start always finds the unit idle and leads into work
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> !arith_st.busy ##1 arith_st.busy)
        else $error("start issued to a busy unit");
`endif

endmodule

// File: test/lcg_random_generator_tb.sv
// ----------------------------------------------------------------------------
// lcg_random_generator_tb
// Self-checking bench for the linear congruential generator. Command beats
// are fed from a backlog with random gaps, result beats are taken with
// random stalls, and every result is checked against an in-bench model of
// the seed update. The APB registers are reprogrammed between phases,
// extremes included, while nothing is in flight.
// ----------------------------------------------------------------------------
module lcg_random_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DRAIN_CYCLES   = 100;
    localparam int          LIMIT_CYCLES   = 800_000;
    localparam int          RANDOM_PHASES  = 8;
    localparam int          BEATS_PER_PHASE = 138;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] seed_value;
    } cmd_beat_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [lcg_pkg::APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lcg_in_if  in_ch ();
    lcg_out_if out_ch ();

    // Model of the generator state and registers
    logic [31:0] seed_model;
    logic [31:0] mult_model;
    logic [31:0] incr_model;
    logic [31:0] mod_model;

    cmd_beat_t   cmd_backlog[$];
    logic [31:0] awaited_values[$];

    int          mismatches = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          send_gap = 0;
    int          recv_gap = 0;

    lcg_random_generator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4ns clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // Next seed: low 32 bits of seed * mult + incr, then reduced if modulus set
    function automatic logic [31:0] next_seed(input logic [31:0] seed);
        logic [63:0] prod;
        logic [31:0] v;
        prod = 64'(seed) * 64'(mult_model);
        v = prod[31:0] + incr_model;
        if (mod_model != 32'd0)
            v = v % mod_model;
        return v;
    endfunction

    // Apply one accepted command beat to the model, queue any expected value
    task automatic absorb_command(input logic [1:0] cmd, input logic [31:0] seed);
        case (cmd)
            lcg_pkg::CMD_STEP:
            begin
                seed_model = next_seed(seed_model);
                awaited_values.push_back(seed_model);
            end
            lcg_pkg::CMD_LOAD:
                seed_model = seed;
            lcg_pkg::CMD_LOAD_STEP:
            begin
                seed_model = next_seed(seed);
                awaited_values.push_back(seed_model);
            end
            default:
                ;
        endcase
    endtask

    // Command driver: hold a beat until taken, otherwise advance the backlog
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid      <= 1'b0;
            in_ch.cmd        <= lcg_pkg::CMD_STEP;
            in_ch.seed_value <= '0;
        end
        else
        begin
            cmd_beat_t beat;
            logic      taken;
            taken = in_ch.valid && in_ch.ready;
            if (taken)
                absorb_command(in_ch.cmd, in_ch.seed_value);
            if (in_ch.valid && !taken)
                ;
            else if (send_gap > 0)
            begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (cmd_backlog.size() > 0)
            begin
                if ($urandom_range(0, 99) < send_idle_pct)
                begin
                    send_gap = $urandom_range(0, 10);
                    in_ch.valid <= 1'b0;
                end
                else
                begin
                    beat = cmd_backlog.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.cmd        <= beat.cmd;
                    in_ch.seed_value <= beat.seed_value;
                end
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Result monitor: check each taken beat, drop ready in random bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            logic [31:0] want;
            if (out_ch.valid && out_ch.ready)
            begin
                if (awaited_values.size() == 0)
                    report_mismatch($sformatf("unexpected random_value %08h",
                                              out_ch.random_value));
                else
                begin
                    want = awaited_values.pop_front();
                    if (out_ch.random_value !== want)
                        report_mismatch($sformatf("random_value %08h, want %08h",
                                                  out_ch.random_value, want));
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < recv_stall_pct)
            begin
                recv_gap = $urandom_range(0, 10);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic apb_write(input lcg_pkg::reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            lcg_pkg::REG_MULT: mult_model = value;
            lcg_pkg::REG_INCR: incr_model = value;
            lcg_pkg::REG_MOD:  mod_model  = value;
            default:           ;
        endcase
    endtask

    task automatic set_registers(input logic [31:0] mult, input logic [31:0] incr,
                                 input logic [31:0] modv);
        apb_write(lcg_pkg::REG_MULT, mult);
        apb_write(lcg_pkg::REG_INCR, incr);
        apb_write(lcg_pkg::REG_MOD, modv);
        @(negedge clk);
    endtask

    task automatic queue_beat(input logic [1:0] cmd, input logic [31:0] seed);
        cmd_beat_t beat;
        beat.cmd        = cmd;
        beat.seed_value = seed;
        cmd_backlog.push_back(beat);
    endtask

    // Wait until nothing is queued, held or awaited, then let the core settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || in_ch.valid || awaited_values.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return ALL_ONES;
            2:       return 32'($urandom_range(0, 255));
            3:       return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_modulus();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 32'd0;
            4, 5:       return 32'($urandom_range(1, 1000));
            6:          return ALL_ONES;
            7:          return 32'h8000_0000 | $urandom;
            default:    return $urandom;
        endcase
    endfunction

    task automatic queue_random_beats(input int count);
        int r;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 58)
                queue_beat(lcg_pkg::CMD_STEP, pick_word());
            else if (r < 80)
                queue_beat(lcg_pkg::CMD_LOAD_STEP, pick_word());
            else if (r < 93)
                queue_beat(lcg_pkg::CMD_LOAD, pick_word());
            else
                queue_beat(CMD_UNUSED, pick_word());
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        seed_model       = lcg_pkg::LCG_RESET_SEED;
        mult_model       = lcg_pkg::LCG_RESET_MULT;
        incr_model       = '0;
        mod_model        = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset registers: steps from the reset seed, loads, load-steps, unused command
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        queue_beat(lcg_pkg::CMD_STEP, 32'h0);
        queue_beat(lcg_pkg::CMD_STEP, ALL_ONES);
        queue_beat(lcg_pkg::CMD_LOAD, 32'h0);
        queue_beat(lcg_pkg::CMD_STEP, 32'h0);
        queue_beat(lcg_pkg::CMD_LOAD_STEP, ALL_ONES);
        queue_beat(CMD_UNUSED, 32'hAAAA_AAAA);
        queue_beat(lcg_pkg::CMD_STEP, 32'h5555_5555);
        queue_beat(lcg_pkg::CMD_LOAD, 32'h8000_0000);
        queue_beat(lcg_pkg::CMD_LOAD, 32'h1234_5678);
        queue_beat(lcg_pkg::CMD_STEP, 32'h0);
        queue_beat(lcg_pkg::CMD_LOAD_STEP, 32'h1);
        wait_drained();

        // Zero multiplier: every step yields the increment
        set_registers(32'h0, ALL_ONES, 32'h0);
        queue_beat(lcg_pkg::CMD_STEP, 32'h0);
        queue_beat(lcg_pkg::CMD_LOAD_STEP, 32'h5555_5555);
        queue_beat(CMD_UNUSED, ALL_ONES);
        queue_beat(lcg_pkg::CMD_STEP, 32'h0);
        wait_drained();

        // All registers at their maximum
        set_registers(ALL_ONES, ALL_ONES, ALL_ONES);
        queue_beat(lcg_pkg::CMD_LOAD_STEP, ALL_ONES);
        queue_beat(lcg_pkg::CMD_STEP, 32'h0);
        queue_beat(lcg_pkg::CMD_LOAD_STEP, 32'h0);
        queue_beat(lcg_pkg::CMD_STEP, 32'h0);
        wait_drained();

        // Modulus of one: everything reduces to zero
        set_registers(32'd1103515245, 32'd12345, 32'd1);
        queue_beat(lcg_pkg::CMD_STEP, 32'h0);
        queue_beat(lcg_pkg::CMD_LOAD_STEP, ALL_ONES);
        wait_drained();

        // Random phases; the last one runs without gaps or stalls
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == RANDOM_PHASES - 1)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            else
            begin
                send_idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
                recv_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            end
            set_registers(pick_word(), pick_word(), pick_modulus());
            queue_random_beats(BEATS_PER_PHASE);
            wait_drained();
        end

        if (awaited_values.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_values.size()));

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
